/* rtl/cwt_pkg.sv */
// Shared types and constants for the time-dependent AUC unit.
// No dependencies.
`timescale 1ns / 1ps
package cwt_pkg;

  localparam int unsigned MAX_ITEMS_DEF  = 1024;
  localparam int unsigned SCORE_BITS_DEF = 16;
  localparam int unsigned TIME_W         = 16;
  localparam int unsigned AUC_W          = 16;

  // exp(x) = 2^(x*log2 e); polynomial for 2^f on a Q16 fraction
  localparam logic signed [16:0] LOG2E_Q14 = 17'sd23637;
  localparam logic [15:0] EXP_C1 = 16'd45603;
  localparam logic [15:0] EXP_C2 = 16'd14815;
  localparam logic [15:0] EXP_C3 = 16'd5118;

  // datapath commands
  typedef struct packed {
    logic load;        // capture an input word
    logic write;       // store subject if at risk
    logic latch_k;     // capture outer element
    logic acc;         // accumulate inner element
    logic j_before_k;  // inner index precedes outer index
    logic div_tp0;     // start TP division before element
    logic div_tp1;     // start TP division after element
    logic div_fin;     // start final area division
    logic add_q;       // add finished TP point to sum
    logic out_load;    // load result register, clear counts
    logic no_ctrl;     // result is the no-controls case
  } cwt_cmd_t;

  typedef struct packed {
    logic last;
    logic rd_flag;
    logic div_done;
    logic no_ctrl;
  } cwt_stat_t;

endpackage

/* rtl/cwt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module cwt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/cwt_div.sv */
// Restoring long divider, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
module cwt_div #(
  parameter int unsigned DW = 48,
  parameter int unsigned NW = 27,
  parameter int unsigned QW = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DW-1:0]            rem0_i,
  input  logic [NW-1:0]            num_i,
  input  logic [DW-1:0]            den_i,
  input  logic [$clog2(QW+1)-1:0]  steps_i,
  output logic                     done_o,
  output logic [QW-1:0]            quo_o
);

  localparam int unsigned SCW = $clog2(QW + 1);

  logic           busy_q;
  logic [SCW-1:0] cnt_q;
  logic [DW-1:0]  rem_q, den_q;
  logic [NW-1:0]  nsh_q;
  logic [QW-1:0]  quo_q;
  logic [DW:0]    shifted;
  logic           ge;

  assign shifted = {rem_q, nsh_q[NW-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign done_o  = busy_q && (cnt_q == '0);
  assign quo_o   = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - SCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem0_i;
      nsh_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q && (cnt_q != '0)) begin
      rem_q <= ge ? DW'(shifted - {1'b0, den_q}) : DW'(shifted);
      nsh_q <= nsh_q << 1;
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

endmodule

/* rtl/cwt_datapath.sv */
// Datapath: input capture, exp weight pipeline, subject store, rank sums,
// divider and result register. Depends on cwt_pkg, cwt_ram, cwt_div.
`timescale 1ns / 1ps
module cwt_datapath import cwt_pkg::*; #(
  parameter int unsigned MAX_ITEMS  = MAX_ITEMS_DEF,
  parameter int unsigned SCORE_BITS = SCORE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [TIME_W-1:0]             cfg_data_i,
  input  logic signed [15:0]            risk_score_i,
  input  logic [TIME_W-1:0]             event_time_i,
  input  logic                          event_status_i,
  input  logic                          last_item_i,
  input  cwt_cmd_t                      cmd_i,
  input  logic [$clog2(MAX_ITEMS)-1:0]  rd_addr_i,
  output cwt_stat_t                     stat_o,
  output logic [$clog2(MAX_ITEMS+1)-1:0] kept_o,
  output logic [AUC_W-1:0]              auc_value_o
);

  localparam int unsigned SB   = SCORE_BITS;
  localparam int unsigned CW   = $clog2(MAX_ITEMS + 1);
  localparam int unsigned AW   = $clog2(MAX_ITEMS);
  localparam int unsigned WT_W = 32 + CW;
  localparam int unsigned SUMW = 34 + CW;
  localparam int unsigned NUMW = SUMW - 17;
  localparam int unsigned QW   = (NUMW > 32) ? NUMW : 32;
  localparam int unsigned SCW  = $clog2(QW + 1);
  localparam int unsigned DW   = SB + 33;
  localparam int unsigned TW   = SB + 17;
  localparam int unsigned TS   = (TW > 31) ? TW + 1 : 32;
  localparam logic signed [TS-1:0] LIM = TS'(33'sd1073741824);

  // captured word and configuration
  logic [TIME_W-1:0]    tt_q;
  logic signed [SB-1:0] sc_q;
  logic [TIME_W-1:0]    etime_q;
  logic                 status_q, last_q;

  // exp pipeline, free running on the held word
  logic signed [TS-1:0] t_q;
  logic [30:0]          u_q;
  logic [16:0]          p1_q, p2_q;
  logic [17:0]          m_q;
  logic [TS-1:0]        ut;
  logic [15:0]          f;
  logic [4:0]           ip;
  logic [31:0]          m1;
  logic [33:0]          m2, m3;
  logic [48:0]          sh;
  logic [31:0]          w;

  // store and counts
  logic [CW-1:0]   kept_q, cases_q, ctrl;
  logic [WT_W-1:0] wt_q;
  logic            keep, full, case_c, we;
  logic [DW-1:0]   rdata;
  logic signed [SB-1:0] rs;
  logic [31:0]     rw;

  // scan
  logic signed [SB-1:0] sk_q;
  logic [31:0]          wk_q;
  logic [WT_W-1:0]      p_q;
  logic [SUMW-1:0]      sum_q;
  logic                 age_q;
  logic [AUC_W-1:0]     auc_q;

  // divider
  logic            dv_start, dv_done;
  logic [WT_W-1:0] dv_rem0, dv_den, a_val;
  logic [NUMW-1:0] dv_num;
  logic [SCW-1:0]  dv_steps;
  logic [QW-1:0]   quo;
  logic [32:0]     tp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tt_q <= '0;
    end else if (cfg_we_i) begin
      tt_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sc_q     <= SB'(risk_score_i);
      etime_q  <= event_time_i;
      status_q <= event_status_i;
      last_q   <= last_item_i;
    end
  end

  assign ut = t_q + LIM;
  assign f  = u_q[25:10];
  assign ip = u_q[30:26];
  assign m1 = 32'(EXP_C3) * 32'(f);
  assign m2 = 34'(p1_q) * 34'(f);
  assign m3 = 34'(p2_q) * 34'(f);

  always_ff @(posedge clk_i) begin
    t_q <= TS'(sc_q) * TS'(LOG2E_Q14);
    if (t_q < -LIM) begin
      u_q <= '0;
    end else if (t_q > LIM - TS'(1)) begin
      u_q <= '1;
    end else begin
      u_q <= ut[30:0];
    end
    p1_q <= 17'(EXP_C2) + 17'(m1 >> 16);
    p2_q <= 17'(EXP_C1) + 17'(m2 >> 16);
    m_q  <= 18'(65536) + 18'(m3 >> 16);
  end

  always_comb begin
    if (ip >= 5'd16) begin
      sh = 49'(m_q) << (ip - 5'd16);
    end else begin
      sh = 49'(m_q) >> (5'd16 - ip);
    end
    w = (|sh[48:32]) ? '1 : sh[31:0];
  end

  assign keep   = etime_q >= tt_q;
  assign full   = kept_q == CW'(MAX_ITEMS);
  assign case_c = (etime_q == tt_q) && status_q;
  assign we     = cmd_i.write && keep && !full;
  assign ctrl   = kept_q - cases_q;

  cwt_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (kept_q[AW-1:0]),
    .wdata_i ({case_c, w, sc_q}),
    .raddr_i (rd_addr_i),
    .rdata_o (rdata)
  );

  assign rs = rdata[SB-1:0];
  assign rw = rdata[SB+31:SB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q  <= '0;
      cases_q <= '0;
      wt_q    <= '0;
      sum_q   <= '0;
    end else if (cmd_i.out_load) begin
      kept_q  <= '0;
      cases_q <= '0;
      wt_q    <= '0;
      sum_q   <= '0;
    end else begin
      if (we) begin
        kept_q  <= kept_q + CW'(1);
        cases_q <= cases_q + CW'(case_c);
        wt_q    <= wt_q + WT_W'(w);
      end
      if (cmd_i.add_q) begin
        sum_q <= sum_q + SUMW'(tp);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_k) begin
      sk_q <= rs;
      wk_q <= rw;
      p_q  <= '0;
    end else if (cmd_i.acc) begin
      if ((rs < sk_q) || ((rs == sk_q) && cmd_i.j_before_k)) begin
        p_q <= p_q + WT_W'(rw);
      end
    end
    if (cmd_i.div_tp0 || cmd_i.div_tp1) begin
      age_q <= a_val >= wt_q;
    end
    if (cmd_i.out_load) begin
      if (cmd_i.no_ctrl) begin
        auc_q <= '0;
      end else begin
        auc_q <= (|quo[QW-1:AUC_W]) ? '1 : quo[AUC_W-1:0];
      end
    end
  end

  assign a_val    = cmd_i.div_tp1 ? (wt_q - p_q - WT_W'(wk_q)) : (wt_q - p_q);
  assign dv_start = cmd_i.div_tp0 || cmd_i.div_tp1 || cmd_i.div_fin;
  assign dv_rem0  = cmd_i.div_fin ? '0 : a_val;
  assign dv_num   = cmd_i.div_fin ? sum_q[SUMW-1:17] : '0;
  assign dv_den   = cmd_i.div_fin ? WT_W'(ctrl) : wt_q;
  assign dv_steps = cmd_i.div_fin ? SCW'(NUMW) : SCW'(32);
  assign tp       = age_q ? 33'h1_0000_0000 : {1'b0, quo[31:0]};

  cwt_div #(.DW(WT_W), .NW(NUMW), .QW(QW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .rem0_i  (dv_rem0),
    .num_i   (dv_num),
    .den_i   (dv_den),
    .steps_i (dv_steps),
    .done_o  (dv_done),
    .quo_o   (quo)
  );

  assign stat_o.last     = last_q;
  assign stat_o.rd_flag  = rdata[DW-1];
  assign stat_o.div_done = dv_done;
  assign stat_o.no_ctrl  = ctrl == '0;
  assign kept_o          = kept_q;
  assign auc_value_o     = auc_q;

endmodule

/* rtl/cwt_ctrl.sv */
// Controller: sequences loading, the rank scan, divisions and result handoff.
// Depends on cwt_pkg.
`timescale 1ns / 1ps
module cwt_ctrl import cwt_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic                           no_controls_o,
  input  cwt_stat_t                      stat_i,
  input  logic [$clog2(MAX_ITEMS+1)-1:0] kept_i,
  output cwt_cmd_t                       cmd_o,
  output logic [$clog2(MAX_ITEMS)-1:0]   rd_addr_o
);

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned AW = $clog2(MAX_ITEMS);

  typedef enum logic [3:0] {
    S_IDLE, S_EXP, S_WR, S_CHK, S_ORD, S_OLAT, S_IRD, S_IACC,
    S_D0, S_W0, S_W1, S_FIN, S_FW, S_OUT
  } state_e;

  state_e        state_q;
  logic [2:0]    ec_q;
  logic [CW-1:0] k_q, j_q;
  logic          ov_q, nc_q, nco_q;
  logic          take, put;

  assign take = ov_q && !out_stall_i;
  assign put  = (state_q == S_OUT) && (!ov_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ec_q    <= '0;
      k_q     <= '0;
      j_q     <= '0;
      ov_q    <= 1'b0;
      nc_q    <= 1'b0;
      nco_q   <= 1'b0;
    end else begin
      // output flag held with the result word while it waits
      if (put) begin
        ov_q  <= 1'b1;
        nco_q <= nc_q;
      end else if (take) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            ec_q    <= '0;
            state_q <= S_EXP;
          end
        end
        S_EXP: begin
          ec_q <= ec_q + 3'd1;
          if (ec_q == 3'd4) begin
            state_q <= S_WR;
          end
        end
        S_WR: begin
          state_q <= stat_i.last ? S_CHK : S_IDLE;
        end
        S_CHK: begin
          k_q <= '0;
          if (stat_i.no_ctrl) begin
            nc_q    <= 1'b1;
            state_q <= S_OUT;
          end else begin
            nc_q    <= 1'b0;
            state_q <= S_ORD;
          end
        end
        S_ORD: state_q <= S_OLAT;
        S_OLAT: begin
          j_q <= '0;
          if (!stat_i.rd_flag) begin
            state_q <= S_IRD;
          end else if (k_q + CW'(1) == kept_i) begin
            state_q <= S_FIN;
          end else begin
            k_q     <= k_q + CW'(1);
            state_q <= S_ORD;
          end
        end
        S_IRD: state_q <= S_IACC;
        S_IACC: begin
          j_q     <= j_q + CW'(1);
          state_q <= (j_q + CW'(1) == kept_i) ? S_D0 : S_IRD;
        end
        S_D0: state_q <= S_W0;
        S_W0: begin
          if (stat_i.div_done) begin
            state_q <= S_W1;
          end
        end
        S_W1: begin
          if (stat_i.div_done) begin
            if (k_q + CW'(1) == kept_i) begin
              state_q <= S_FIN;
            end else begin
              k_q     <= k_q + CW'(1);
              state_q <= S_ORD;
            end
          end
        end
        S_FIN: state_q <= S_FW;
        S_FW: begin
          if (stat_i.div_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (put) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = (state_q == S_IDLE) && in_valid_i;
    cmd_o.write      = state_q == S_WR;
    cmd_o.latch_k    = state_q == S_OLAT;
    cmd_o.acc        = state_q == S_IACC;
    cmd_o.j_before_k = j_q < k_q;
    cmd_o.div_tp0    = state_q == S_D0;
    cmd_o.div_tp1    = (state_q == S_W0) && stat_i.div_done;
    cmd_o.div_fin    = state_q == S_FIN;
    cmd_o.add_q      = ((state_q == S_W0) || (state_q == S_W1)) && stat_i.div_done;
    cmd_o.out_load   = put;
    cmd_o.no_ctrl    = nc_q;
  end

  // outer index while fetching the outer element, inner index otherwise
  assign rd_addr_o     = (state_q == S_ORD) ? k_q[AW-1:0] : j_q[AW-1:0];
  assign in_stall_o    = state_q != S_IDLE;
  assign out_valid_o   = ov_q;
  assign no_controls_o = nco_q;

endmodule

/* rtl/cox_weighted_time_auc_unit.sv */
// Loading: a subject word passes the 5-stage exp weight pipeline, then one store
// write. A last word then runs the rank scan over the kept subjects, paced by the
// single store read port and the bit-serial divider (one quotient bit per cycle).
// Throughput: one word at a time.
// Reset clears counts, target time and result valid; the store needs no clearing.
`timescale 1ns / 1ps
module cox_weighted_time_auc_unit import cwt_pkg::*; #(
  parameter int unsigned MAX_ITEMS  = MAX_ITEMS_DEF,
  parameter int unsigned SCORE_BITS = SCORE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [TIME_W-1:0]  cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] risk_score_i,
  input  logic [TIME_W-1:0]  event_time_i,
  input  logic               event_status_i,
  input  logic               last_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [AUC_W-1:0]   auc_value_o,
  output logic               no_controls_o
);

  cwt_cmd_t                      cmd;
  cwt_stat_t                     stat;
  logic [$clog2(MAX_ITEMS+1)-1:0] kept;
  logic [$clog2(MAX_ITEMS)-1:0]   rd_addr;

  assign cfg_ready_o = 1'b1;

  cwt_ctrl #(.MAX_ITEMS(MAX_ITEMS)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .no_controls_o (no_controls_o),
    .stat_i        (stat),
    .kept_i        (kept),
    .cmd_o         (cmd),
    .rd_addr_o     (rd_addr)
  );

  cwt_datapath #(.MAX_ITEMS(MAX_ITEMS), .SCORE_BITS(SCORE_BITS)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .risk_score_i   (risk_score_i),
    .event_time_i   (event_time_i),
    .event_status_i (event_status_i),
    .last_item_i    (last_item_i),
    .cmd_i          (cmd),
    .rd_addr_i      (rd_addr),
    .stat_o         (stat),
    .kept_o         (kept),
    .auc_value_o    (auc_value_o)
  );

endmodule
